[src/hdct_pkg.sv]
// ----------------------------------------------------------------------------
// hdct_pkg: shared types and constants
// Sizes, item kinds, controller states and the command/status bundles that
// pass between controller and datapath.
// ----------------------------------------------------------------------------
package hdct_pkg;

  localparam int BINS       = 256;
  localparam int COUNT_W    = 20;
  localparam int LVL_W      = 8;
  localparam int BIN_W      = $clog2(BINS);
  localparam int LAST_BIN   = BINS - 1;
  localparam int DIV_CNT_W  = $clog2(COUNT_W);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic capture;
    logic div_step;
    logic setup;
    logic walk;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic walk_last;
  } sts_t;

endpackage

[src/hdct_div.sv]
// ----------------------------------------------------------------------------
// hdct_div: iterative unsigned divider
// Restoring division of a count-wide dividend by a level-wide divisor, one
// quotient bit per step.
// ----------------------------------------------------------------------------
module hdct_div
  import hdct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               step,
  input  logic [COUNT_W-1:0] dividend,
  input  logic [LVL_W-1:0]   divisor,
  output logic [COUNT_W-1:0] quot,
  output logic [LVL_W-1:0]   rem,
  output logic               last
);

  logic [LVL_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LVL_W:0]       shifted;
  logic [LVL_W:0]       diff;
  logic                 ge;

  assign shifted = {rem, quot[COUNT_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};
  assign last    = cnt == DIV_CNT_W'(COUNT_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (step) begin
      // shift in the next dividend bit, subtract where it fits
      quot <= {quot[COUNT_W-2:0], ge};
      rem  <= ge ? diff[LVL_W-1:0] : shifted[LVL_W-1:0];
    end
  end

endmodule

[src/hdct_dp.sv]
// ----------------------------------------------------------------------------
// hdct_dp: histogram store and chord walk datapath
// Holds the bin memory with per-bin valid bits, the largest loaded count,
// the incremental chord stepper and the deepest-gap search.
// ----------------------------------------------------------------------------
module hdct_dp
  import hdct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [LVL_W-1:0]   bin_index,
  input  logic [COUNT_W-1:0] bin_count,
  input  logic [LVL_W-1:0]   first_peak_level,
  input  logic [COUNT_W-1:0] first_peak_height,
  input  logic [LVL_W-1:0]   second_peak_level,
  input  logic [COUNT_W-1:0] second_peak_height,
  output logic [LVL_W-1:0]   threshold,
  output logic [COUNT_W-1:0] max_gap,
  output logic [COUNT_W-1:0] peak_count,
  output logic               status
);

  // bin storage
  logic [COUNT_W-1:0] mem [BINS];
  logic [BINS-1:0]    vld;
  logic [COUNT_W-1:0] mem_q;
  logic               vld_q;
  logic [COUNT_W-1:0] largest;

  // query registers
  logic [LVL_W-1:0]   x;
  logic [LVL_W-1:0]   last_x;
  logic [LVL_W-1:0]   dx;
  logic               neg;
  logic               empty;
  logic [COUNT_W-1:0] q;
  logic [LVL_W-1:0]   r;
  logic [COUNT_W:0]   dq;
  logic [LVL_W-1:0]   dr;

  // evaluation stage
  logic               eval_valid;
  logic [LVL_W-1:0]   eval_x;
  logic [COUNT_W-1:0] eval_chord;

  logic [COUNT_W-1:0] best;
  logic [LVL_W-1:0]   thr;
  logic               bad_order;

  logic [COUNT_W-1:0] mag_in;
  logic [LVL_W-1:0]   dx_in;
  logic [COUNT_W-1:0] quot;
  logic [LVL_W-1:0]   rem;
  logic               div_last;

  logic [LVL_W:0]     rsum;
  logic               wrap;
  logic [COUNT_W+1:0] qsum;
  logic [COUNT_W-1:0] h;
  logic [COUNT_W-1:0] gap;
  logic               in_range;

  assign mag_in = (second_peak_height >= first_peak_height)
                ? second_peak_height - first_peak_height
                : first_peak_height - second_peak_height;
  assign dx_in  = second_peak_level - first_peak_level;

  hdct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.capture),
    .step     (cmd.div_step),
    .dividend (mag_in),
    .divisor  (dx_in),
    .quot     (quot),
    .rem      (rem),
    .last     (div_last)
  );

  assign in_range = int'(bin_index) < BINS;

  // histogram writes and clearing
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vld     <= '0;
      largest <= '0;
    end else if (cmd.load && in_range) begin
      vld[BIN_W'(bin_index)] <= 1'b1;
      if (bin_count > largest) begin
        largest <= bin_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      mem[BIN_W'(bin_index)] <= bin_count;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[BIN_W'(x)];
    vld_q <= vld[BIN_W'(x)];
  end

  // chord stepping: remainder kept below dx, carry into the quotient
  assign rsum = {1'b0, r} + {1'b0, dr};
  assign wrap = rsum >= {1'b0, dx};
  assign qsum = {2'b00, q} + {dq[COUNT_W], dq} + {{(COUNT_W + 1){1'b0}}, wrap};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x         <= first_peak_level;
      last_x    <= (int'(second_peak_level) > LAST_BIN) ? LVL_W'(LAST_BIN)
                                                        : second_peak_level;
      dx        <= dx_in;
      neg       <= second_peak_height < first_peak_height;
      empty     <= int'(first_peak_level) > LAST_BIN;
      bad_order <= second_peak_level <= first_peak_level;
      q         <= first_peak_height;
      r         <= '0;
    end else if (cmd.setup) begin
      // turn |dy| / dx into a floored signed step
      if (!neg) begin
        dq <= {1'b0, quot};
        dr <= rem;
      end else if (rem == '0) begin
        dq <= '0 - {1'b0, quot};
        dr <= '0;
      end else begin
        dq <= ~{1'b0, quot};
        dr <= dx - rem;
      end
    end else if (cmd.walk) begin
      x <= x + 1'b1;
      q <= qsum[COUNT_W-1:0];
      r <= wrap ? LVL_W'(rsum - {1'b0, dx}) : rsum[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      eval_x     <= x;
      eval_chord <= q;
    end
  end

  assign h   = vld_q ? mem_q : '0;
  assign gap = (h >= eval_chord) ? h - eval_chord : eval_chord - h;

  // keep the first bin with the largest gap
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best <= '0;
      thr  <= first_peak_level;
    end else if (eval_valid && gap > best) begin
      best <= gap;
      thr  <= eval_x;
    end
  end

  assign sts.skip      = bad_order || empty;
  assign sts.div_last  = div_last;
  assign sts.walk_last = x == last_x;

  assign threshold  = thr;
  assign max_gap    = best;
  assign peak_count = largest;
  assign status     = bad_order;

endmodule

[src/hdct_ctrl.sv]
// ----------------------------------------------------------------------------
// hdct_ctrl: transaction controller
// Accepts items, sequences a query through divide, setup, walk and drain,
// and raises the result strobe.
// ----------------------------------------------------------------------------
module hdct_ctrl
  import hdct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_QUERY) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (sts.skip) state_next = ST_DONE;
        else if (sts.div_last) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        if (sts.walk_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = state != ST_IDLE;
    done = state == ST_DONE;
    unique case (state)
      ST_IDLE: begin
        cmd.clear   = accept && kind == KIND_CLEAR;
        cmd.load    = accept && kind == KIND_LOAD;
        cmd.capture = accept && kind == KIND_QUERY;
      end
      ST_DIV:   cmd.div_step = !sts.skip;
      ST_SETUP: cmd.setup = 1'b1;
      ST_WALK:  cmd.walk = 1'b1;
      default: begin
      end
    endcase
  end

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_QUERY) |=> busy)
    else $error("query accepted but controller not busy");

  a_simple_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != KIND_QUERY) |=> !busy)
    else $error("clear or load left controller busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result strobe longer than one cycle");

  a_walk_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> $past(cmd.setup) || $past(cmd.walk))
    else $error("walk started without chord setup");

endmodule

[src/histogram_deepest_concavity_threshold.sv]
// ----------------------------------------------------------------------------
// histogram_deepest_concavity_threshold: deepest-concavity threshold search
// Grey-level histogram with clear, single-bin load and a chord walk that
// returns the first bin with the largest gap below or above the chord.
//
//   channel   ports                                  handshake
//   -------   -------------------------------------  -----------------------
//   item in   kind, bin_index, bin_count, peaks       start & !busy
//   result    threshold, max_gap, peak_count, status  done, one cycle
//
// Clear and load leave the controller idle; the next item is accepted the cycle after.
// A query keeps busy high through divide, setup, the walk over bins x1 .. x2
// and drain, with the one-bit-per-cycle divider and one bin read a cycle.
// Peaks out of order: the query goes from divide straight to done, result with status set.
// Reset (rst, synchronous) empties the histogram at once via per-bin valid bits.
// Results are shown for one cycle under done and cannot be stalled.
// ----------------------------------------------------------------------------
module histogram_deepest_concavity_threshold
  import hdct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [LVL_W-1:0]   bin_index,
  input  logic [COUNT_W-1:0] bin_count,
  input  logic [LVL_W-1:0]   first_peak_level,
  input  logic [COUNT_W-1:0] first_peak_height,
  input  logic [LVL_W-1:0]   second_peak_level,
  input  logic [COUNT_W-1:0] second_peak_height,
  output logic               done,
  output logic [LVL_W-1:0]   threshold,
  output logic [COUNT_W-1:0] max_gap,
  output logic [COUNT_W-1:0] peak_count,
  output logic               status
);

  cmd_t cmd;
  sts_t sts;

  hdct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  hdct_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .bin_index          (bin_index),
    .bin_count          (bin_count),
    .first_peak_level   (first_peak_level),
    .first_peak_height  (first_peak_height),
    .second_peak_level  (second_peak_level),
    .second_peak_height (second_peak_height),
    .threshold          (threshold),
    .max_gap            (max_gap),
    .peak_count         (peak_count),
    .status             (status)
  );

endmodule
